### rtl/core/mfei_pkg.sv
// Package: types, codes and record layout for the MIDI file event indexer.
`timescale 1ns / 1ps
`default_nettype none
package mfei_pkg;
    localparam int OffsetBits = 32;
    localparam logic [31:0] IdHeader = 32'h4D546864;
    localparam logic [31:0] IdTrack  = 32'h4D54726B;

    typedef enum logic [2:0] {
        KIND_CHAN  = 3'd0,
        KIND_SYSEX = 3'd1,
        KIND_META  = 3'd2,
        KIND_HDR   = 3'd3,
        KIND_TRK   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_MTHD  = 3'd1,
        ERR_HDR_LEN  = 3'd2,
        ERR_TRK_ID   = 3'd3,
        ERR_NEG_LEN  = 3'd4,
        ERR_NO_RUN   = 3'd5,
        ERR_DATA_HI  = 3'd6,
        ERR_META_TYP = 3'd7
    } err_t;

    typedef enum logic [11:0] {
        PH_HDR_ID    = 12'b000000000001,
        PH_HDR_LEN   = 12'b000000000010,
        PH_HDR_BODY  = 12'b000000000100,
        PH_TRK_ID    = 12'b000000001000,
        PH_TRK_LEN   = 12'b000000010000,
        PH_DELTA     = 12'b000000100000,
        PH_STATUS    = 12'b000001000000,
        PH_DATA1     = 12'b000010000000,
        PH_DATA2     = 12'b000100000000,
        PH_META_TYPE = 12'b001000000000,
        PH_LEN       = 12'b010000000000,
        PH_PAYLOAD   = 12'b100000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] track_number;
        logic [31:0] record_offset;
        logic [31:0] record_length;
        logic [27:0] delta_time;
        logic [7:0]  status_byte;
        logic        used_running_status;
        logic [6:0]  first_param;
        logic [6:0]  second_param;
        logic [7:0]  meta_kind;
        logic [27:0] payload_length;
        logic [2:0]  error_code;
    } rec_t;
endpackage
`default_nettype wire

### rtl/core/mfei_if.sv
// Interfaces: valid/ready channels for input bytes and output records.
`timescale 1ns / 1ps
`default_nettype none
interface mfei_in_if;
    import mfei_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mfei_out_if;
    import mfei_pkg::*;
    logic valid;
    logic ready;
    rec_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/mfei_parser.sv
// Front part: byte-wise SMF parse state machine producing record candidates.
`timescale 1ns / 1ps
`default_nettype none
module mfei_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire mfei_pkg::in_item_t item,
    output mfei_pkg::rec_t         rec,
    output logic                   rec_valid
);
    import mfei_pkg::*;

    localparam int Ob = OffsetBits;

    phase_t          phase_reg, phase_next;
    logic [Ob-1:0]   pos_reg, pos_next;
    logic [Ob-1:0]   end_reg, end_next;
    logic [31:0]     shift_reg, shift_next;
    logic [1:0]      fcnt_reg, fcnt_next;
    logic [27:0]     vacc_reg, vacc_next;
    logic [2:0]      vcnt_reg, vcnt_next;
    logic [7:0]      run_reg, run_next;
    logic [Ob-1:0]   evoff_reg, evoff_next;
    logic [27:0]     evdelta_reg, evdelta_next;
    logic [3:0]      evcnt_reg, evcnt_next;
    logic [7:0]      evmeta_reg, evmeta_next;
    logic [6:0]      evp1_reg, evp1_next;
    logic            evrun_reg, evrun_next;
    kind_t           evkind_reg, evkind_next;
    logic [27:0]     prem_reg, prem_next;
    logic [15:0]     trk_reg, trk_next;
    logic            halt_reg, halt_next;

    // effective state after a restart byte
    phase_t          ph;
    logic [Ob-1:0]   pos, pos1;
    logic [31:0]     sh, shn;
    logic [1:0]      fc;
    logic [27:0]     va, vsum;
    logic [2:0]      vc, vcn;
    logic            vdone;
    logic [7:0]      run, b;
    logic [15:0]     trk, ctrk;
    logic            halt;
    logic            sdone;

    function automatic rec_t mk(kind_t k, logic [15:0] t, logic [Ob-1:0] o, err_t e);
        rec_t r;
        r = '0;
        r.record_kind = k;
        r.track_number = t;
        r.record_offset = o[31:0];
        r.error_code = e;
        return r;
    endfunction

    always_comb
    begin
        b    = item.file_byte;
        ph   = item.restart ? PH_HDR_ID : phase_reg;
        pos  = item.restart ? '0 : pos_reg;
        sh   = item.restart ? '0 : shift_reg;
        fc   = item.restart ? '0 : fcnt_reg;
        va   = item.restart ? '0 : vacc_reg;
        vc   = item.restart ? '0 : vcnt_reg;
        run  = item.restart ? '0 : run_reg;
        trk  = item.restart ? '0 : trk_reg;
        halt = item.restart ? 1'b0 : halt_reg;
        ctrk = trk - 16'd1;
        pos1 = pos + 1'b1;
        shn  = {sh[23:0], b};
        vsum = va + {21'd0, b[6:0]};
        vcn  = vc + 3'd1;
        vdone = !(b[7] && (vcn < 3'd4));
        sdone = 1'b0;

        phase_next   = ph;
        pos_next     = pos;
        end_next     = item.restart ? '0 : end_reg;
        shift_next   = sh;
        fcnt_next    = fc;
        vacc_next    = va;
        vcnt_next    = vc;
        run_next     = run;
        evoff_next   = item.restart ? '0 : evoff_reg;
        evdelta_next = evdelta_reg;
        evcnt_next   = evcnt_reg;
        evmeta_next  = evmeta_reg;
        evp1_next    = evp1_reg;
        evrun_next   = evrun_reg;
        evkind_next  = evkind_reg;
        prem_next    = item.restart ? '0 : prem_reg;
        trk_next     = trk;
        halt_next    = halt;
        rec          = '0;
        rec_valid    = 1'b0;

        if (!halt)
        begin
            pos_next = pos1;
            unique case (ph)
                PH_HDR_ID, PH_TRK_ID:
                begin
                    shift_next = shn;
                    fcnt_next  = fc + 2'd1;
                    if (fc == 2'd3)
                    begin
                        if (ph == PH_HDR_ID)
                        begin
                            if (shn != IdHeader)
                            begin
                                rec = mk(KIND_HDR, '0, pos - Ob'(3), ERR_NO_MTHD);
                                rec_valid = 1'b1;
                                halt_next = 1'b1;
                            end
                            else
                                phase_next = PH_HDR_LEN;
                        end
                        else if (shn != IdTrack)
                        begin
                            rec = mk(KIND_TRK, trk, pos - Ob'(3), ERR_TRK_ID);
                            rec_valid = 1'b1;
                            halt_next = 1'b1;
                        end
                        else
                            phase_next = PH_TRK_LEN;
                    end
                end
                PH_HDR_LEN, PH_TRK_LEN:
                begin
                    shift_next = shn;
                    fcnt_next  = fc + 2'd1;
                    if (fc == 2'd3)
                    begin
                        if (shn[31])
                        begin
                            rec = mk((ph == PH_HDR_LEN) ? KIND_HDR : KIND_TRK,
                                     (ph == PH_HDR_LEN) ? 16'd0 : trk,
                                     pos - Ob'(7), ERR_NEG_LEN);
                            rec_valid = 1'b1;
                            halt_next = 1'b1;
                        end
                        else if (ph == PH_HDR_LEN && shn != 32'd6)
                        begin
                            rec = mk(KIND_HDR, '0, pos - Ob'(7), ERR_HDR_LEN);
                            rec_valid = 1'b1;
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            rec = mk((ph == PH_HDR_LEN) ? KIND_HDR : KIND_TRK,
                                     (ph == PH_HDR_LEN) ? 16'd0 : trk,
                                     pos - Ob'(7), ERR_NONE);
                            rec.record_length = shn + 32'd8;
                            rec_valid = 1'b1;
                            end_next = pos1 + Ob'(shn);
                            if (ph == PH_HDR_LEN)
                                phase_next = PH_HDR_BODY;
                            else
                            begin
                                trk_next   = trk + 16'd1;
                                run_next   = '0;
                                phase_next = PH_DELTA;
                                vacc_next  = '0;
                                vcnt_next  = '0;
                            end
                        end
                    end
                end
                PH_HDR_BODY:
                begin
                end
                PH_DELTA:
                begin
                    if (vc == 3'd0)
                    begin
                        evoff_next  = pos;
                        evmeta_next = '0;
                        evp1_next   = '0;
                        evrun_next  = 1'b0;
                        evkind_next = KIND_CHAN;
                    end
                    vcnt_next = vcn;
                    vacc_next = vdone ? vsum : {vsum[20:0], 7'd0};
                    evcnt_next = {1'b0, vcn};
                    if (vdone)
                    begin
                        evdelta_next = vsum;
                        phase_next   = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (b == 8'hF0 || b == 8'hF7 || b == 8'hFF)
                    begin
                        run_next    = '0;
                        evkind_next = (b == 8'hFF) ? KIND_META : KIND_SYSEX;
                        evcnt_next  = evcnt_reg + 4'd1;
                        vacc_next   = '0;
                        vcnt_next   = '0;
                        phase_next  = (b == 8'hFF) ? PH_META_TYPE : PH_LEN;
                    end
                    else if (b[7])
                    begin
                        run_next    = b;
                        evcnt_next  = evcnt_reg + 4'd1;
                        phase_next  = PH_DATA1;
                    end
                    else if (!run[7])
                    begin
                        rec = mk(KIND_CHAN, ctrk, evoff_reg, ERR_NO_RUN);
                        rec_valid = 1'b1;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        evrun_next = 1'b1;
                        evp1_next  = b[6:0];
                        evcnt_next = evcnt_reg + 4'd1;
                        if (run[7:4] == 4'hC || run[7:4] == 4'hD)
                            sdone = 1'b1;
                        else
                            phase_next = PH_DATA2;
                    end
                end
                PH_DATA1:
                begin
                    if (b[7])
                    begin
                        rec = mk(KIND_CHAN, ctrk, evoff_reg, ERR_DATA_HI);
                        rec_valid = 1'b1;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        evp1_next  = b[6:0];
                        evcnt_next = evcnt_reg + 4'd1;
                        if (run[7:4] == 4'hC || run[7:4] == 4'hD)
                            sdone = 1'b1;
                        else
                            phase_next = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    if (b[7])
                    begin
                        rec = mk(KIND_CHAN, ctrk, evoff_reg, ERR_DATA_HI);
                        rec_valid = 1'b1;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        evcnt_next = evcnt_reg + 4'd1;
                        sdone = 1'b1;
                    end
                end
                PH_META_TYPE:
                begin
                    if (b > 8'd128)
                    begin
                        rec = mk(KIND_META, ctrk, evoff_reg, ERR_META_TYP);
                        rec_valid = 1'b1;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        evmeta_next = b;
                        evcnt_next  = evcnt_reg + 4'd1;
                        vacc_next   = '0;
                        vcnt_next   = '0;
                        phase_next  = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    evcnt_next = evcnt_reg + 4'd1;
                    vcnt_next  = vcn;
                    vacc_next  = vdone ? vsum : {vsum[20:0], 7'd0};
                    if (vdone)
                    begin
                        prem_next = vsum;
                        if (vsum == '0)
                            sdone = 1'b1;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    prem_next = prem_reg - 28'd1;
                    if (prem_reg == 28'd1)
                        sdone = 1'b1;
                end
                default:
                    phase_next = PH_HDR_ID;
            endcase

            // deliver a completed event from the updated event fields
            if (sdone)
            begin
                rec = '0;
                rec.record_kind   = evkind_next;
                rec.track_number  = ctrk;
                rec.record_offset = evoff_next[31:0];
                rec.delta_time    = evdelta_next;
                rec.status_byte   = run_next;
                if (evkind_next == KIND_CHAN)
                begin
                    rec.record_length = {28'd0, evcnt_next};
                    rec.used_running_status = evrun_next;
                    rec.first_param  = evp1_next;
                    rec.second_param = (ph == PH_DATA2) ? b[6:0] : 7'd0;
                end
                else
                begin
                    rec.payload_length = (ph == PH_PAYLOAD) ? va : 28'd0;
                    rec.record_length  = {28'd0, evcnt_next} + {4'd0, rec.payload_length};
                    rec.meta_kind = (evkind_next == KIND_META) ? evmeta_next : 8'd0;
                end
                rec_valid  = 1'b1;
                phase_next = PH_DELTA;
                vacc_next  = '0;
                vcnt_next  = '0;
            end

            if (!halt_next && pos1 == end_next &&
                (phase_next == PH_HDR_BODY || phase_next == PH_DELTA ||
                 phase_next == PH_STATUS || phase_next == PH_DATA1 ||
                 phase_next == PH_DATA2 || phase_next == PH_META_TYPE ||
                 phase_next == PH_LEN || phase_next == PH_PAYLOAD))
            begin
                phase_next = PH_TRK_ID;
                shift_next = '0;
                fcnt_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR_ID;
            pos_reg    <= '0;
            end_reg    <= '0;
            shift_reg  <= '0;
            fcnt_reg   <= '0;
            vacc_reg   <= '0;
            vcnt_reg   <= '0;
            run_reg    <= '0;
            evoff_reg  <= '0;
            evkind_reg <= KIND_CHAN;
            prem_reg   <= '0;
            trk_reg    <= '0;
            halt_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            end_reg    <= end_next;
            shift_reg  <= shift_next;
            fcnt_reg   <= fcnt_next;
            vacc_reg   <= vacc_next;
            vcnt_reg   <= vcnt_next;
            run_reg    <= run_next;
            evoff_reg  <= evoff_next;
            evkind_reg <= evkind_next;
            prem_reg   <= prem_next;
            trk_reg    <= trk_next;
            halt_reg   <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            evdelta_reg <= evdelta_next;
            evcnt_reg   <= evcnt_next;
            evmeta_reg  <= evmeta_next;
            evp1_reg    <= evp1_next;
            evrun_reg   <= evrun_next;
        end
    end
endmodule
`default_nettype wire

### rtl/core/mfei_queue.sv
// Back part: two-entry record queue between the parser and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module mfei_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mfei_pkg::rec_t push_data,
    output logic                has_room,
    mfei_out_if.source          out
);
    import mfei_pkg::*;

    rec_t       slot_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = out.valid && out.ready;
    assign out.valid = cnt_reg != 2'd0;
    assign out.data  = slot_reg[rd_reg];
    // room for one more even if nothing leaves this cycle
    assign has_room  = cnt_reg != 2'd2;

    always_comb
    begin
        rd_next  = pop ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end
endmodule
`default_nettype wire

### rtl/core/midi_file_event_indexer_unit.sv
// Top level: Standard MIDI File event indexer.
// Usage:
//   byte_in carries one file byte per transfer with a restart flag that marks
//   byte 0 of a new file. record_out carries at most one record per byte: a
//   chunk header record or a complete event (channel, sysex, meta), with offset,
//   length, delta time and decoded fields, or a record with a nonzero error code.
//   After an error every byte is dropped until one arrives with restart set.
//   Throughput: one byte per cycle while the queue has room. The parser
//   updates its state in the accepting cycle; a record is registered into a
//   two-entry queue that drives record_out.
//   When the receiver stalls the queue fills and byte_in.ready falls once it is
//   full; no record is lost. Reset clears the parser to expect an MThd id and
//   empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module midi_file_event_indexer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfei_in_if.sink     byte_in,
    mfei_out_if.source  record_out
);
    import mfei_pkg::*;

    logic take;
    logic room;
    logic rv;
    rec_t rec;

    assign byte_in.ready = room;
    assign take = byte_in.valid && room;

    mfei_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (byte_in.data),
        .rec       (rec),
        .rec_valid (rv)
    );

    mfei_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && rv),
        .push_data (rec),
        .has_room  (room),
        .out       (record_out)
    );

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        record_out.valid && record_out.data.error_code != ERR_NONE
        |-> record_out.data.record_length == '0)
        else $error("error record carries a length");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> record_out.valid)
        else $error("input stalled with no record waiting");

    a_chunk_kind: assert property (@(posedge clk) disable iff (!rst_n)
        record_out.valid && record_out.data.record_kind != KIND_CHAN
        |-> record_out.data.first_param == '0)
        else $error("non-channel record carries a data byte");
endmodule
`default_nettype wire
